// ===== hdl/assert_macros.svh =====
// assertion macros shared by the serializer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define WSPX_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wspx assertion failed");

// next-cycle implication, checked on every rising edge outside reset
`define WSPX_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wspx assertion failed");

`endif

// ===== hdl/wspx_pkg.sv =====
// package: types, register indexes and constants of the led serializer
`timescale 1ns / 1ps

package wspx_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int COLOR_W        = 8;
    localparam int TIME_W         = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int PIXEL_BITS     = 24;
    localparam int BITS_LEFT_W    = 5;

    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RED_CORR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_CORR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_CORR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_ONE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_ZERO   = 3'd6;

    localparam logic [COLOR_W-1:0] BRIGHTNESS_RST = 8'd255;
    localparam logic [COLOR_W-1:0] RED_CORR_RST   = 8'd255;
    localparam logic [COLOR_W-1:0] GREEN_CORR_RST = 8'd208;
    localparam logic [COLOR_W-1:0] BLUE_CORR_RST  = 8'd208;
    localparam logic [TIME_W-1:0]  BIT_PERIOD_RST = 16'd1200;
    localparam logic [TIME_W-1:0]  HIGH_ONE_RST   = 16'd900;
    localparam logic [TIME_W-1:0]  HIGH_ZERO_RST  = 16'd300;

    localparam logic [BITS_LEFT_W-1:0] BITS_PER_PIXEL = 5'd24;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_CORR,
        ST_MUL_BRIGHT,
        ST_COMMIT
    } state_t;

    typedef enum logic [1:0] {
        CH_GREEN,
        CH_RED,
        CH_BLUE
    } chan_t;

    typedef struct packed {
        logic  capture;
        logic  mul_corr;
        logic  mul_bright;
        chan_t chan;
        logic  tick;
        logic  load_pixel;
    } cmd_t;

    typedef struct packed {
        logic need_scale;
    } stat_t;

endpackage

// ===== hdl/wspx_pixel_if.sv =====
// request channel carrying one tick with an optional pixel
`timescale 1ns / 1ps

interface wspx_pixel_if;
    logic       valid;
    logic       ready;
    logic       pixel_valid;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, pixel_valid, red, green, blue, input ready);
    modport sink   (input valid, pixel_valid, red, green, blue, output ready);
endinterface

// ===== hdl/wspx_result_if.sv =====
// result channel carrying the line level and status of one tick
`timescale 1ns / 1ps

interface wspx_result_if;
    logic valid;
    logic ready;
    logic line_level;
    logic pixel_taken;
    logic busy_res;

    modport source (output valid, line_level, pixel_taken, busy_res, input ready);
    modport sink   (input valid, line_level, pixel_taken, busy_res, output ready);
endinterface

// ===== hdl/wspx_ctrl.sv =====
// controller: sequences channel scaling and commits one tick per request
`timescale 1ns / 1ps

module wspx_ctrl
    import wspx_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  logic  out_ready,
    output logic  out_valid,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    chan_t  chan_reg, chan_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chan_reg      <= CH_GREEN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && out_free && stat.need_scale)
                begin
                    state_next = ST_MUL_CORR;
                    chan_next  = CH_GREEN;
                end
            end
            ST_MUL_CORR:
            begin
                state_next = ST_MUL_BRIGHT;
            end
            ST_MUL_BRIGHT:
            begin
                unique case (chan_reg)
                    CH_GREEN:
                    begin
                        chan_next  = CH_RED;
                        state_next = ST_MUL_CORR;
                    end
                    CH_RED:
                    begin
                        chan_next  = CH_BLUE;
                        state_next = ST_MUL_CORR;
                    end
                    default:
                    begin
                        state_next = ST_COMMIT;
                    end
                endcase
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.chan = chan_reg;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = out_free;
                if (in_valid && out_free)
                begin
                    // a pixel to take needs scaling first, any other tick commits now
                    if (stat.need_scale)
                    begin
                        cmd.capture = 1'b1;
                    end
                    else
                    begin
                        cmd.tick = 1'b1;
                    end
                end
            end
            ST_MUL_CORR:
            begin
                cmd.mul_corr = 1'b1;
            end
            ST_MUL_BRIGHT:
            begin
                cmd.mul_bright = 1'b1;
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.tick       = 1'b1;
                    cmd.load_pixel = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.tick)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

// ===== hdl/wspx_dp.sv =====
// datapath: config registers, shared scaling multipliers, bit timer and shifter
`timescale 1ns / 1ps

module wspx_dp
    import wspx_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  pix_valid,
    input  logic [COLOR_W-1:0]    red,
    input  logic [COLOR_W-1:0]    green,
    input  logic [COLOR_W-1:0]    blue,
    output logic                  line_level,
    output logic                  pixel_taken,
    output logic                  busy_res
);

    localparam int CMP_W  = (TIMER_BITS > TIME_W) ? TIMER_BITS : TIME_W;
    localparam int PROD_W = 2 * COLOR_W;
    localparam int FULL_W = 3 * COLOR_W;

    logic [COLOR_W-1:0] brightness_reg;
    logic [COLOR_W-1:0] red_corr_reg;
    logic [COLOR_W-1:0] green_corr_reg;
    logic [COLOR_W-1:0] blue_corr_reg;
    logic [TIME_W-1:0]  bit_period_reg;
    logic [TIME_W-1:0]  high_one_reg;
    logic [TIME_W-1:0]  high_zero_reg;

    logic [COLOR_W-1:0] red_in_reg, green_in_reg, blue_in_reg;
    logic [COLOR_W-1:0] red_sc_reg, green_sc_reg, blue_sc_reg;
    logic [PROD_W-1:0]  prod_reg;

    logic [PIXEL_BITS-1:0]  shift_reg, shift_next;
    logic [BITS_LEFT_W-1:0] bits_left_reg, bits_left_next;
    logic [TIMER_BITS-1:0]  count_reg, count_next;
    logic [TIME_W-1:0]      high_time_reg, high_time_next;

    logic line_reg, taken_reg, busy_reg;
    logic line_next;

    logic [COLOR_W-1:0]     mul_value, mul_corr;
    logic [FULL_W-1:0]      full_prod;
    logic [PIXEL_BITS-1:0]  word0;
    logic [BITS_LEFT_W-1:0] left0;
    logic [TIMER_BITS-1:0]  count_eff;
    logic                   count_max, bit_start;

    assign stat.need_scale = pix_valid && (bits_left_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= BRIGHTNESS_RST;
            red_corr_reg   <= RED_CORR_RST;
            green_corr_reg <= GREEN_CORR_RST;
            blue_corr_reg  <= BLUE_CORR_RST;
            bit_period_reg <= BIT_PERIOD_RST;
            high_one_reg   <= HIGH_ONE_RST;
            high_zero_reg  <= HIGH_ZERO_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BRIGHTNESS: brightness_reg <= cfg_data[COLOR_W-1:0];
                REG_RED_CORR:   red_corr_reg   <= cfg_data[COLOR_W-1:0];
                REG_GREEN_CORR: green_corr_reg <= cfg_data[COLOR_W-1:0];
                REG_BLUE_CORR:  blue_corr_reg  <= cfg_data[COLOR_W-1:0];
                REG_BIT_PERIOD: bit_period_reg <= cfg_data[TIME_W-1:0];
                REG_HIGH_ONE:   high_one_reg   <= cfg_data[TIME_W-1:0];
                REG_HIGH_ZERO:  high_zero_reg  <= cfg_data[TIME_W-1:0];
                default:        ;
            endcase
        end
    end

    // shared multipliers: value * correction, then the product * brightness
    always_comb
    begin
        unique case (cmd.chan)
            CH_GREEN:
            begin
                mul_value = green_in_reg;
                mul_corr  = green_corr_reg;
            end
            CH_RED:
            begin
                mul_value = red_in_reg;
                mul_corr  = red_corr_reg;
            end
            default:
            begin
                mul_value = blue_in_reg;
                mul_corr  = blue_corr_reg;
            end
        endcase
    end

    assign full_prod = FULL_W'(prod_reg) * FULL_W'(brightness_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            red_in_reg   <= red;
            green_in_reg <= green;
            blue_in_reg  <= blue;
        end
        if (cmd.mul_corr)
        begin
            prod_reg <= PROD_W'(mul_value) * PROD_W'(mul_corr);
        end
        if (cmd.mul_bright)
        begin
            unique case (cmd.chan)
                CH_GREEN: green_sc_reg <= full_prod[FULL_W-1:PROD_W];
                CH_RED:   red_sc_reg   <= full_prod[FULL_W-1:PROD_W];
                default:  blue_sc_reg  <= full_prod[FULL_W-1:PROD_W];
            endcase
        end
    end

    // one tick of the waveform generator
    always_comb
    begin
        word0 = cmd.load_pixel ? {green_sc_reg, red_sc_reg, blue_sc_reg} : shift_reg;
        left0 = cmd.load_pixel ? BITS_PER_PIXEL : bits_left_reg;

        count_max = (count_reg == '1);
        bit_start = (left0 != '0) &&
                    ((CMP_W'(count_reg) >= CMP_W'(bit_period_reg)) || count_max);

        shift_next     = word0;
        bits_left_next = left0;
        high_time_next = high_time_reg;
        count_eff      = count_reg;
        if (bit_start)
        begin
            high_time_next = word0[PIXEL_BITS-1] ? high_one_reg : high_zero_reg;
            count_eff      = '0;
            shift_next     = {word0[PIXEL_BITS-2:0], 1'b0};
            bits_left_next = left0 - BITS_LEFT_W'(1);
        end

        line_next  = CMP_W'(count_eff) < CMP_W'(high_time_next);
        count_next = (count_eff == '1) ? count_eff : count_eff + TIMER_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= '0;
            bits_left_reg <= '0;
            count_reg     <= '0;
            high_time_reg <= '0;
        end
        else if (cmd.tick)
        begin
            shift_reg     <= shift_next;
            bits_left_reg <= bits_left_next;
            count_reg     <= count_next;
            high_time_reg <= high_time_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg  <= 1'b0;
            taken_reg <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else if (cmd.tick)
        begin
            line_reg  <= line_next;
            taken_reg <= cmd.load_pixel;
            busy_reg  <= (bits_left_next != '0);
        end
    end

    assign line_level  = line_reg;
    assign pixel_taken = taken_reg;
    assign busy_res    = busy_reg;

endmodule

// ===== hdl/ws2812_pixel_serializer_unit.sv =====
// top level of the one-wire led pixel serializer
`timescale 1ns / 1ps
// usage:
// each request on the pixel channel is one tick of the led waveform generator;
// it may carry a pixel (pixel_valid) that is taken when no bits are left to send.
// each request yields exactly one result: the line level for that tick, whether
// the pixel was taken, and whether bits of a pixel are still to start.
// a tick that takes no pixel is committed in the cycle it is accepted, so while
// results are taken such ticks run at one per cycle; each result shows next cycle.
// a tick that takes a pixel holds the channel during scaling: the three channels
// go in turn through two shared multipliers (correction, then brightness), then
// the tick commits and its result goes to the output register; ready is low
// meanwhile, and also while the commit waits on a stalled result.
// the result sits in an output register; a new request is taken while it waits
// only if the receiver takes it in that same cycle, so a stalled receiver stops
// the request channel after one pending result.
// config writes (cfg_we, cfg_index, cfg_data) are taken at once and belong to
// idle periods. reset loads the register defaults, clears the shifter and timer,
// and drives the line low.

`include "assert_macros.svh"

module ws2812_pixel_serializer_unit
    import wspx_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    wspx_pixel_if.sink            pixel,
    wspx_result_if.source         result
);

    cmd_t  cmd;
    stat_t stat;

    wspx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel.valid),
        .in_ready  (pixel.ready),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    wspx_dp #(
        .TIMER_BITS (TIMER_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pix_valid   (pixel.pixel_valid),
        .red         (pixel.red),
        .green       (pixel.green),
        .blue        (pixel.blue),
        .line_level  (result.line_level),
        .pixel_taken (result.pixel_taken),
        .busy_res    (result.busy_res)
    );

    // a fresh pixel always leaves bits to send
    `WSPX_ASSERT_IMP(a_taken_busy, result.valid && result.pixel_taken, result.busy_res)
    // a request is never taken while a stalled result would be overwritten
    `WSPX_ASSERT_IMP(a_no_overrun, pixel.ready, !result.valid || result.ready)
    // taking a pixel starts the scaling sequence, so no request next cycle
    `WSPX_ASSERT_NXT(a_scale_stall, pixel.valid && pixel.ready && stat.need_scale,
        !pixel.ready)

endmodule
